>>> rtl/kmt_pkg.sv
// shared types, constants and codes for the key matrix translator
`timescale 1ns / 1ps
`default_nettype none

package kmt_pkg;

    localparam int TABLE_DEPTH   = 128;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_INDEX_W = 7;
    localparam int WIDE_W        = ((IDX_W > ENTRY_INDEX_W) ? IDX_W : ENTRY_INDEX_W) + 1;

    localparam int NUM_KEYS    = 256;
    localparam int KEY_W       = $clog2(NUM_KEYS);
    localparam int NUM_COLS    = 8;
    localparam int ROW_W       = 7;
    localparam int CODE_W      = 8;
    localparam int COL_W       = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OPC_KEY   = 2'd0;
    localparam logic [1:0] OPC_READ  = 2'd1;
    localparam logic [1:0] OPC_WRITE = 2'd2;

    localparam logic [CODE_W-1:0] SHIFT_LEFT  = 8'h2A;
    localparam logic [CODE_W-1:0] SHIFT_RIGHT = 8'h36;
    localparam logic [ROW_W-1:0]  ROW_ALL     = 7'h7F;

    typedef enum logic [1:0] {
        OP_KEY,
        OP_READ,
        OP_WRITE,
        OP_NONE
    } kmt_op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_WALK
    } kmt_state_t;

    typedef struct packed {
        logic [CODE_W-1:0] first_code;
        logic [CODE_W-1:0] second_code;
        logic [ROW_W-1:0]  row_mask_a;
        logic [COL_W-1:0]  column_a;
        logic [ROW_W-1:0]  row_mask_b;
        logic [COL_W-1:0]  column_b;
    } kmt_entry_t;

    typedef struct packed {
        kmt_op_t           op;
        logic [CODE_W-1:0] scan_code;
        logic              pressed;
        logic [NUM_COLS-1:0] column_select;
        logic [IDX_W-1:0]  table_addr;
        logic              write_ok;
        kmt_entry_t        entry;
    } kmt_item_t;

endpackage

`default_nettype wire

>>> rtl/kmt_front.sv
// front end: transaction intake, opcode classification and command queue
`timescale 1ns / 1ps
`default_nettype none

module kmt_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  opcode,
    input  wire logic [7:0]                  scan_code,
    input  wire logic                        pressed,
    input  wire logic [7:0]                  column_select,
    input  wire logic [6:0]                  entry_index,
    input  wire logic [7:0]                  first_code,
    input  wire logic [7:0]                  second_code,
    input  wire logic [6:0]                  row_mask_a,
    input  wire logic [2:0]                  column_a,
    input  wire logic [6:0]                  row_mask_b,
    input  wire logic [2:0]                  column_b,
    output logic                             q_valid,
    output kmt_pkg::kmt_item_t               q_item,
    input  wire logic                        q_pop
);
    import kmt_pkg::*;

    kmt_item_t          queue_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    kmt_item_t          item_in;
    logic [WIDE_W-1:0]  idx_wide;
    logic               push;
    logic               pop;

    always_comb
    begin
        idx_wide                  = WIDE_W'(entry_index);
        item_in.scan_code         = (scan_code == SHIFT_RIGHT) ? SHIFT_LEFT : scan_code;
        item_in.pressed           = pressed;
        item_in.column_select     = column_select;
        item_in.table_addr        = idx_wide[IDX_W-1:0];
        item_in.write_ok          = (idx_wide < WIDE_W'(TABLE_DEPTH));
        item_in.entry.first_code  = first_code;
        item_in.entry.second_code = second_code;
        item_in.entry.row_mask_a  = row_mask_a;
        item_in.entry.column_a    = column_a;
        item_in.entry.row_mask_b  = row_mask_b;
        item_in.entry.column_b    = column_b;
        unique case (opcode)
            OPC_KEY:   item_in.op = OP_KEY;
            OPC_READ:  item_in.op = OP_READ;
            OPC_WRITE: item_in.op = OP_WRITE;
            default:   item_in.op = OP_NONE;
        endcase
    end

    assign busy    = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = queue_reg[rd_ptr_reg];
    assign push    = start && !busy;
    assign pop     = q_pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

>>> rtl/kmt_back.sv
// back end: key state, translation table walk, column masks and results
`timescale 1ns / 1ps
`default_nettype none

module kmt_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  kmt_pkg::kmt_item_t       q_item,
    output logic                     q_pop,
    output logic                     done,
    output logic [6:0]               row_bits,
    output logic                     key_irq
);
    import kmt_pkg::*;

    kmt_state_t          state_reg;
    kmt_state_t          state_next;
    kmt_item_t           cur_reg;
    logic                key_mem [NUM_KEYS];
    logic [ROW_W-1:0]    col_rows_reg [NUM_COLS];
    logic [TABLE_DEPTH-1:0] valid_reg;
    kmt_entry_t          table_mem [TABLE_DEPTH];
    logic [CNT_W-1:0]    issue_cnt_reg;
    logic [KEY_W-1:0]    clr_cnt_reg;
    logic                pend_reg;
    kmt_entry_t          ent_reg;
    logic                ent_valid_reg;
    logic                look_reg;
    kmt_entry_t          look_ent_reg;
    logic                look_valid_reg;
    logic                first_down_reg;
    logic                second_down_reg;
    logic                done_reg;
    logic [ROW_W-1:0]    row_bits_reg;
    logic                key_irq_reg;

    logic                issue_more;
    logic                issue;
    logic [IDX_W-1:0]    issue_addr;
    logic                clearing;
    logic                clr_last;
    logic                key_wr;
    logic [KEY_W-1:0]    key_wr_addr;
    logic                key_wr_data;
    logic                ent_end;
    logic                ent_single_hit;
    logic                ent_double_hit;
    logic                ent_apply;
    logic                walk_done;
    logic                key_start;
    logic                table_write;
    logic                res_fire;
    logic [ROW_W-1:0]    res_rows;
    logic                res_irq;
    logic [ROW_W-1:0]    read_acc;

    assign issue_more = (issue_cnt_reg != CNT_W'(TABLE_DEPTH));
    assign issue_addr = issue_cnt_reg[IDX_W-1:0];
    assign clearing   = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
    assign clr_last   = (clr_cnt_reg == KEY_W'(NUM_KEYS - 1));

    // table read, then key state lookup, then evaluation
    always_comb
    begin
        ent_end        = !look_valid_reg
                         || (look_ent_reg.first_code == '0 && look_ent_reg.second_code == '0);
        ent_single_hit = !ent_end && look_ent_reg.first_code != '0
                         && look_ent_reg.second_code == '0 && first_down_reg;
        ent_double_hit = !ent_end && look_ent_reg.first_code != '0
                         && look_ent_reg.second_code != '0
                         && first_down_reg && second_down_reg;
        ent_apply      = look_reg && (ent_single_hit || ent_double_hit);
        walk_done      = (look_reg && (ent_end || ent_double_hit))
                         || (!pend_reg && !issue_more);
    end

    // or of the selected active-low columns
    always_comb
    begin
        read_acc = '0;
        for (int c = 0; c < NUM_COLS; c++)
        begin
            if (!cur_reg.column_select[c])
            begin
                read_acc = read_acc | col_rows_reg[c];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cur_reg.op != OP_KEY)
                begin
                    state_next = ST_IDLE;
                end
                else if (!cur_reg.pressed && cur_reg.scan_code == SHIFT_LEFT)
                begin
                    state_next = ST_CLEAR;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop       = 1'b0;
        issue       = 1'b0;
        key_start   = 1'b0;
        table_write = 1'b0;
        res_fire    = 1'b0;
        res_rows    = ROW_ALL;
        res_irq     = 1'b0;
        key_wr      = 1'b0;
        key_wr_addr = cur_reg.scan_code;
        key_wr_data = cur_reg.pressed;
        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                key_wr      = 1'b1;
                key_wr_addr = clr_cnt_reg;
                key_wr_data = 1'b0;
            end
            ST_IDLE:
            begin
                q_pop = q_valid;
            end
            ST_EXEC:
            begin
                key_start   = (cur_reg.op == OP_KEY);
                key_wr      = (cur_reg.op == OP_KEY);
                table_write = (cur_reg.op == OP_WRITE) && cur_reg.write_ok;
                res_fire    = (cur_reg.op != OP_KEY);
                if (cur_reg.op == OP_READ)
                begin
                    res_rows = ~read_acc;
                end
            end
            ST_WALK:
            begin
                issue    = !walk_done && issue_more;
                res_fire = walk_done;
                res_irq  = cur_reg.pressed;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            valid_reg   <= '0;
            clr_cnt_reg <= '0;
            pend_reg    <= 1'b0;
            look_reg    <= 1'b0;
            done_reg    <= 1'b0;
            for (int c = 0; c < NUM_COLS; c++)
            begin
                col_rows_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= res_fire;
            pend_reg  <= issue;
            look_reg  <= pend_reg && !walk_done;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (table_write)
            begin
                valid_reg[cur_reg.table_addr] <= 1'b1;
            end
            for (int c = 0; c < NUM_COLS; c++)
            begin
                if (key_start)
                begin
                    col_rows_reg[c] <= '0;
                end
                else if (ent_apply)
                begin
                    col_rows_reg[c] <= col_rows_reg[c]
                        | ((look_ent_reg.column_a == COL_W'(c)) ? look_ent_reg.row_mask_a : '0)
                        | ((look_ent_reg.column_b == COL_W'(c)) ? look_ent_reg.row_mask_b : '0);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_wr)
        begin
            key_mem[key_wr_addr] <= key_wr_data;
        end
        if (pend_reg)
        begin
            first_down_reg  <= key_mem[ent_reg.first_code];
            second_down_reg <= key_mem[ent_reg.second_code];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
        if (key_start)
        begin
            issue_cnt_reg <= '0;
        end
        else if (issue)
        begin
            issue_cnt_reg <= issue_cnt_reg + 1'b1;
        end
        if (table_write)
        begin
            table_mem[cur_reg.table_addr] <= cur_reg.entry;
        end
        if (issue)
        begin
            ent_reg       <= table_mem[issue_addr];
            ent_valid_reg <= valid_reg[issue_addr];
        end
        if (pend_reg)
        begin
            look_ent_reg   <= ent_reg;
            look_valid_reg <= ent_valid_reg;
        end
        row_bits_reg <= res_rows;
        key_irq_reg  <= res_irq;
    end

    assign done     = done_reg;
    assign row_bits = row_bits_reg;
    assign key_irq  = key_irq_reg;

endmodule

`default_nettype wire

>>> rtl/key_matrix_translator.sv
// top level of the key matrix translator
//
// A transaction is taken when start is high and busy is low; busy rises only
// when the two-entry command queue is full. Every transaction gives exactly
// one result, shown for one cycle with done high, in the order taken; the
// receiver cannot stall it. After reset the back end clears the key state
// before it starts the first transaction; up to two transactions queue
// meanwhile. A column read, a table write or an unused opcode, once at the
// head of the queue with the back end idle, is popped into the command
// register, fires its result in the exec state and raises done through the
// done register. A key event walks the translation table through its
// single read port, one entry per cycle behind a registered lookup of the
// key state; the walk ends at the first empty or unwritten entry, at a
// matching double-key entry or after the last entry. Releasing shift clears
// the key state before the walk. Reset clears the column masks and the
// table valid bits at once.
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_translator (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] opcode,
    input  wire logic [7:0] scan_code,
    input  wire logic       pressed,
    input  wire logic [7:0] column_select,
    input  wire logic [6:0] entry_index,
    input  wire logic [7:0] first_code,
    input  wire logic [7:0] second_code,
    input  wire logic [6:0] row_mask_a,
    input  wire logic [2:0] column_a,
    input  wire logic [6:0] row_mask_b,
    input  wire logic [2:0] column_b,
    output logic            done,
    output logic [6:0]      row_bits,
    output logic            key_irq
);
    import kmt_pkg::*;

    logic      q_valid;
    logic      q_pop;
    kmt_item_t q_item;

    kmt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .scan_code     (scan_code),
        .pressed       (pressed),
        .column_select (column_select),
        .entry_index   (entry_index),
        .first_code    (first_code),
        .second_code   (second_code),
        .row_mask_a    (row_mask_a),
        .column_a      (column_a),
        .row_mask_b    (row_mask_b),
        .column_b      (column_b),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    kmt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .done     (done),
        .row_bits (row_bits),
        .key_irq  (key_irq)
    );

endmodule

`default_nettype wire

>>> tb/tb_key_matrix_translator.sv
// self-checking testbench for the key matrix translator: directed and random transactions
`timescale 1ns / 1ps

module tb_key_matrix_translator;

    import kmt_pkg::*;

    typedef struct {
        logic [ROW_W-1:0] row_bits;
        logic             key_irq;
    } matrix_result_t;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 140;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [1:0] opcode = '0;
    logic [7:0] scan_code = '0;
    logic       pressed = 1'b0;
    logic [7:0] column_select = '0;
    logic [6:0] entry_index = '0;
    logic [7:0] first_code = '0;
    logic [7:0] second_code = '0;
    logic [6:0] row_mask_a = '0;
    logic [2:0] column_a = '0;
    logic [6:0] row_mask_b = '0;
    logic [2:0] column_b = '0;
    logic       busy;
    logic       done;
    logic [6:0] row_bits;
    logic       key_irq;

    // predictor state
    bit               key_state [NUM_KEYS];
    logic [ROW_W-1:0] col_rows [NUM_COLS];
    kmt_entry_t       entry_table [TABLE_DEPTH];

    matrix_result_t pending_results [$];
    int             errors = 0;
    int             idle_pct = 0;
    int             cycle_count = 0;

    logic [7:0] code_pool [12] = '{8'h01, 8'h10, 8'h11, 8'h1E, 8'h1F, 8'h20,
                                   8'h2A, 8'h36, 8'h39, 8'h48, 8'h80, 8'hFF};

    key_matrix_translator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .scan_code     (scan_code),
        .pressed       (pressed),
        .column_select (column_select),
        .entry_index   (entry_index),
        .first_code    (first_code),
        .second_code   (second_code),
        .row_mask_a    (row_mask_a),
        .column_a      (column_a),
        .row_mask_b    (row_mask_b),
        .column_b      (column_b),
        .done          (done),
        .row_bits      (row_bits),
        .key_irq       (key_irq)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic void rebuild_column_rows();
        kmt_entry_t e;
        bit         walking;
        walking = 1'b1;
        foreach (col_rows[c])
            col_rows[c] = '0;
        for (int i = 0; i < TABLE_DEPTH && walking; i++)
        begin
            e = entry_table[i];
            if (e.first_code == 0 && e.second_code == 0)
                walking = 1'b0;
            else if (e.first_code != 0)
            begin
                if (e.second_code == 0)
                begin
                    if (key_state[e.first_code])
                    begin
                        col_rows[e.column_a] |= e.row_mask_a;
                        col_rows[e.column_b] |= e.row_mask_b;
                    end
                end
                else if (key_state[e.first_code] && key_state[e.second_code])
                begin
                    col_rows[e.column_a] |= e.row_mask_a;
                    col_rows[e.column_b] |= e.row_mask_b;
                    walking = 1'b0;
                end
            end
        end
    endfunction

    function automatic matrix_result_t predict_result(kmt_op_t op, logic [7:0] code,
                                                      logic down, logic [7:0] sel,
                                                      logic [6:0] idx, kmt_entry_t ent);
        matrix_result_t   r;
        logic [7:0]       k;
        logic [ROW_W-1:0] acc;
        r.row_bits = ROW_ALL;
        r.key_irq = 1'b0;
        acc = '0;
        case (op)
            OP_KEY:
            begin
                k = (code == SHIFT_RIGHT) ? SHIFT_LEFT : code;
                if (down)
                begin
                    key_state[k] = 1'b1;
                    r.key_irq = 1'b1;
                end
                else
                begin
                    key_state[k] = 1'b0;
                    if (k == SHIFT_LEFT)
                        foreach (key_state[j])
                            key_state[j] = 1'b0;
                end
                rebuild_column_rows();
            end
            OP_READ:
            begin
                for (int c = 0; c < NUM_COLS; c++)
                    if (!sel[c])
                        acc |= col_rows[c];
                r.row_bits = ~acc;
            end
            OP_WRITE:
            begin
                if (idx < TABLE_DEPTH)
                    entry_table[idx] = ent;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin : check_results
        matrix_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result with none pending: row_bits %h key_irq %b",
                                          row_bits, key_irq));
            else
            begin
                exp_r = pending_results.pop_front();
                if (row_bits !== exp_r.row_bits)
                    report_mismatch($sformatf("row_bits expected %h got %h",
                                              exp_r.row_bits, row_bits));
                if (key_irq !== exp_r.key_irq)
                    report_mismatch($sformatf("key_irq expected %b got %b",
                                              exp_r.key_irq, key_irq));
            end
        end
    end

    // drives one transaction, waits for it to be taken, then maybe idles
    task automatic send_txn(kmt_op_t op, logic [7:0] code, logic down, logic [7:0] sel,
                            logic [6:0] idx, kmt_entry_t ent);
        int gap;
        opcode        <= op;
        scan_code     <= code;
        pressed       <= down;
        column_select <= sel;
        entry_index   <= idx;
        first_code    <= ent.first_code;
        second_code   <= ent.second_code;
        row_mask_a    <= ent.row_mask_a;
        column_a      <= ent.column_a;
        row_mask_b    <= ent.row_mask_b;
        column_b      <= ent.column_b;
        start         <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_result(op, code, down, sel, idx, ent));
        if ($urandom_range(99) < idle_pct)
        begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 140) : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic kmt_entry_t make_entry(logic [7:0] f, logic [7:0] s, logic [6:0] ra,
                                              logic [2:0] ca, logic [6:0] rb, logic [2:0] cb);
        kmt_entry_t e;
        e.first_code  = f;
        e.second_code = s;
        e.row_mask_a  = ra;
        e.column_a    = ca;
        e.row_mask_b  = rb;
        e.column_b    = cb;
        return e;
    endfunction

    function automatic kmt_entry_t noise_entry();
        return make_entry(8'($urandom), 8'($urandom), 7'($urandom), 3'($urandom),
                          7'($urandom), 3'($urandom));
    endfunction

    function automatic logic [7:0] pick_code();
        return code_pool[$urandom_range(11)];
    endfunction

    task automatic key_txn(logic [7:0] code, logic down);
        send_txn(OP_KEY, code, down, 8'($urandom), 7'($urandom), noise_entry());
    endtask

    task automatic read_txn(logic [7:0] sel);
        send_txn(OP_READ, 8'($urandom), 1'($urandom), sel, 7'($urandom), noise_entry());
    endtask

    task automatic write_txn(logic [6:0] idx, kmt_entry_t ent);
        send_txn(OP_WRITE, 8'($urandom), 1'($urandom), 8'($urandom), idx, ent);
    endtask

    task automatic test_empty_table();
        read_txn(8'h00);
        key_txn(8'hFF, 1'b1);
        read_txn(8'hFF);
        read_txn(8'h00);
    endtask

    task automatic test_single_keys();
        write_txn(7'd0, make_entry(8'h1E, 8'h00, 7'h7F, 3'd0, 7'h01, 3'd7));
        write_txn(7'd1, make_entry(8'hFF, 8'h00, 7'h55, 3'd3, 7'h2A, 3'd4));
        key_txn(8'h1E, 1'b1);
        read_txn(8'hFE);
        read_txn(8'h7F);
        read_txn(8'hE7);
    endtask

    task automatic test_combo_and_lone_second();
        write_txn(7'd2, make_entry(8'h2A, 8'h10, 7'h40, 3'd5, 7'h03, 3'd6));
        write_txn(7'd3, make_entry(8'h00, 8'h11, 7'h7F, 3'd1, 7'h7F, 3'd2));
        write_txn(7'd4, make_entry(8'h11, 8'h00, 7'h08, 3'd6, 7'h10, 3'd1));
        key_txn(8'h36, 1'b1);
        key_txn(8'h10, 1'b1);
        key_txn(8'h11, 1'b1);
        read_txn(8'h00);
        key_txn(8'h10, 1'b0);
        read_txn(8'h00);
    endtask

    task automatic test_shift_release();
        key_txn(8'h36, 1'b0);
        read_txn(8'h00);
    endtask

    task automatic test_unused_opcode();
        send_txn(OP_NONE, 8'hFF, 1'b1, 8'h00, 7'h7F, make_entry(8'hFF, 8'hFF, 7'h7F, 3'd7,
                                                              7'h7F, 3'd7));
    endtask

    task automatic test_random(int count);
        kmt_entry_t e;
        logic [7:0] code;
        int         r;
        repeat (count)
        begin
            r = $urandom_range(99);
            if (r < 20)
            begin
                r = $urandom_range(9);
                if (r == 0)
                    e = make_entry(8'h00, 8'h00, 7'($urandom), 3'($urandom), 7'($urandom),
                                   3'($urandom));
                else if (r == 1)
                    e = make_entry(8'h00, pick_code(), 7'($urandom), 3'($urandom),
                                   7'($urandom), 3'($urandom));
                else
                begin
                    e = noise_entry();
                    e.first_code = ($urandom_range(9) == 0) ? 8'($urandom) : pick_code();
                    e.second_code = ($urandom_range(2) == 0) ? pick_code() : 8'h00;
                end
                write_txn(($urandom_range(99) < 85) ? 7'($urandom_range(15))
                                                    : 7'($urandom_range(127)), e);
            end
            else if (r < 65)
            begin
                code = ($urandom_range(99) < 85) ? pick_code() : 8'($urandom_range(255));
                if (code == SHIFT_LEFT || code == SHIFT_RIGHT)
                    key_txn(code, $urandom_range(99) < 80);
                else
                    key_txn(code, $urandom_range(99) < 60);
            end
            else if (r < 95)
            begin
                r = $urandom_range(9);
                read_txn((r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom));
            end
            else
                send_txn(OP_NONE, 8'($urandom), 1'($urandom), 8'($urandom), 7'($urandom),
                         noise_entry());
        end
    endtask

    // no terminator anywhere, so every key event walks the whole table
    task automatic test_full_table();
        kmt_entry_t e;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            e = noise_entry();
            e.first_code = pick_code();
            e.second_code = (i == TABLE_DEPTH - 1) ? 8'h48 : 8'h00;
            if (i == TABLE_DEPTH - 1)
                e.first_code = 8'h39;
            write_txn(7'(i), e);
        end
        key_txn(8'h39, 1'b1);
        key_txn(8'h48, 1'b1);
        read_txn(8'h00);
        key_txn(8'h01, 1'b1);
        read_txn(8'h55);
        key_txn(8'h2A, 1'b0);
        read_txn(8'h00);
    endtask

    initial
    begin
        foreach (col_rows[c])
            col_rows[c] = '0;
        foreach (entry_table[i])
            entry_table[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_pct = 20;
        test_empty_table();
        test_single_keys();
        test_combo_and_lone_second();
        test_shift_release();
        test_unused_opcode();
        test_random(100);
        idle_pct = 49;
        test_random(100);
        idle_pct = 0;
        test_random(100);
        test_full_table();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/kmt_pkg.sv
rtl/kmt_front.sv
rtl/kmt_back.sv
rtl/key_matrix_translator.sv
tb/tb_key_matrix_translator.sv
